// File: hdl/rcr_pkg.sv
// ----------------------------------------------------------------------------
// rcr_pkg
// shared types and constants of the chunk stream reassembler
// ----------------------------------------------------------------------------
package rcr_pkg;

    // chunk header formats
    localparam logic [1:0] FMT_FULL        = 2'd0;
    localparam logic [1:0] FMT_SAME_STREAM = 2'd1;
    localparam logic [1:0] FMT_SAME_LEN    = 2'd2;
    localparam logic [1:0] FMT_CONT        = 2'd3;

    localparam logic [23:0] CHUNK_SIZE_RESET = 24'd128;

    typedef enum logic [1:0] {
        ST_WAIT_DATA  = 2'd0,
        ST_WAIT_CHUNK = 2'd1,
        ST_COMPLETE   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOKUP,
        S_RESOLVE,
        S_DECIDE,
        S_PUSH
    } t_state;

    // one entry of the per-channel table
    typedef struct packed {
        logic        in_progress;
        logic [23:0] received;
        logic [31:0] delta;
        logic [31:0] timestamp;
        logic [7:0]  msg_type;
        logic [23:0] length;
    } t_chan_entry;

    typedef struct packed {
        logic clear_wr;
        logic capture;
        logic lookup;
        logic resolve;
        logic decide;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
    } t_dp_status;

endpackage

// File: hdl/rtmp_chunk_reassembler.sv
// ----------------------------------------------------------------------------
// rtmp_chunk_reassembler
// per-channel chunk header resolution and message progress tracking
// ----------------------------------------------------------------------------
//  channel | direction | handshake                  | word
//  in      | input     | i_in_valid / o_in_stall    | one chunk header + bytes available
//  out     | output    | o_out_valid / i_out_stall  | status, take, offset, length, type, ts
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | chunk size, 24 bits
//
//  an item passes table read, resolve, decide and write back, output load, and the next
//  header is accepted only once the result is loaded into the output word
//  after reset a clearing pass writes every table entry, with o_in_stall high
//  a stalled output holds the next item in the push step until the word drains
// ----------------------------------------------------------------------------
module rtmp_chunk_reassembler #(
    parameter int CHANNELS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [5:0]  i_channel,
    input  logic [1:0]  i_header_format,
    input  logic [23:0] i_msg_len_in,
    input  logic [7:0]  i_msg_type_in,
    input  logic [31:0] i_timestamp_in,
    input  logic [31:0] i_delta_in,
    input  logic [23:0] i_bytes_available,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [23:0] o_take_bytes,
    output logic [23:0] o_write_offset,
    output logic [23:0] o_msg_total_len,
    output logic [7:0]  o_msg_type,
    output logic [31:0] o_msg_timestamp,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [23:0] i_cfg_data
);

    rcr_pkg::t_cmd       w_cmd;
    rcr_pkg::t_dp_status w_dp_status;

    assign o_cfg_ready = 1'b1;

    rcr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_dp_status (w_dp_status),
        .o_cmd       (w_cmd)
    );

    rcr_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_dp_status       (w_dp_status),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_data        (i_cfg_data),
        .i_channel         (i_channel),
        .i_header_format   (i_header_format),
        .i_msg_len_in      (i_msg_len_in),
        .i_msg_type_in     (i_msg_type_in),
        .i_timestamp_in    (i_timestamp_in),
        .i_delta_in        (i_delta_in),
        .i_bytes_available (i_bytes_available),
        .o_status          (o_status),
        .o_take_bytes      (o_take_bytes),
        .o_write_offset    (o_write_offset),
        .o_msg_total_len   (o_msg_total_len),
        .o_msg_type        (o_msg_type),
        .o_msg_timestamp   (o_msg_timestamp)
    );

endmodule

// File: hdl/rcr_ram.sv
// ----------------------------------------------------------------------------
// rcr_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module rcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/rcr_ctrl.sv
// ----------------------------------------------------------------------------
// rcr_ctrl
// sequencer: table clear after reset, then lookup, resolve, decide, push
// ----------------------------------------------------------------------------
module rcr_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  rcr_pkg::t_dp_status i_dp_status,
    output rcr_pkg::t_cmd       o_cmd
);

    rcr_pkg::t_state r_state;
    rcr_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            w_slot_free;

    assign w_slot_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rcr_pkg::S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        unique case (r_state)
            rcr_pkg::S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_dp_status.clear_last) begin
                    n_state = rcr_pkg::S_IDLE;
                end
            end
            rcr_pkg::S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = rcr_pkg::S_LOOKUP;
                end
            end
            rcr_pkg::S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = rcr_pkg::S_RESOLVE;
            end
            rcr_pkg::S_RESOLVE: begin
                o_cmd.resolve = 1'b1;
                n_state       = rcr_pkg::S_DECIDE;
            end
            rcr_pkg::S_DECIDE: begin
                o_cmd.decide = 1'b1;
                n_state      = rcr_pkg::S_PUSH;
            end
            rcr_pkg::S_PUSH: begin
                // wait for the output register to drain
                if (w_slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = rcr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rcr_pkg::S_CLEAR;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: hdl/rcr_dp.sv
// ----------------------------------------------------------------------------
// rcr_dp
// header registers, per-channel table, resolve and chunk sizing arithmetic
// ----------------------------------------------------------------------------
module rcr_dp #(
    parameter int CHANNELS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rcr_pkg::t_cmd       i_cmd,
    output rcr_pkg::t_dp_status o_dp_status,
    input  logic                i_cfg_valid,
    input  logic [23:0]         i_cfg_data,
    input  logic [5:0]          i_channel,
    input  logic [1:0]          i_header_format,
    input  logic [23:0]         i_msg_len_in,
    input  logic [7:0]          i_msg_type_in,
    input  logic [31:0]         i_timestamp_in,
    input  logic [31:0]         i_delta_in,
    input  logic [23:0]         i_bytes_available,
    output logic [1:0]          o_status,
    output logic [23:0]         o_take_bytes,
    output logic [23:0]         o_write_offset,
    output logic [23:0]         o_msg_total_len,
    output logic [7:0]          o_msg_type,
    output logic [31:0]         o_msg_timestamp
);

    localparam int AW = $clog2(CHANNELS);
    localparam int EW = $bits(rcr_pkg::t_chan_entry);

    // channel modulo table depth, restoring remainder over six steps
    function automatic logic [AW-1:0] chan_index(input logic [5:0] ch);
        logic [16:0] v;
        logic [16:0] m;
        begin
            v = 17'(ch);
            for (int k = 5; k >= 0; k--) begin
                m = 17'(CHANNELS) << k;
                if (v >= m) begin
                    v = v - m;
                end
            end
            return v[AW-1:0];
        end
    endfunction

    logic [23:0] r_chunk_size;

    logic [5:0]  r_channel;
    logic [1:0]  r_fmt;
    logic [23:0] r_len_in;
    logic [7:0]  r_type_in;
    logic [31:0] r_ts_in;
    logic [31:0] r_delta_in;
    logic [23:0] r_avail;

    logic [AW-1:0] r_clr_addr;
    logic [AW-1:0] w_idx;

    logic                 w_we;
    logic [AW-1:0]        w_waddr;
    rcr_pkg::t_chan_entry w_wentry;
    logic [EW-1:0]        w_rdata;
    rcr_pkg::t_chan_entry w_entry;

    // resolved header
    logic [23:0] r_len;
    logic [7:0]  r_type;
    logic [31:0] r_ts;
    logic [31:0] r_delta;
    logic [23:0] r_done;
    logic [23:0] r_need;
    logic [23:0] n_len;
    logic [7:0]  n_type;
    logic [31:0] n_ts;
    logic [31:0] n_delta;
    logic [23:0] n_done;
    logic [24:0] w_diff;

    // chunk decision
    logic [23:0]      w_csz;
    logic [23:0]      w_size;
    logic             w_ok;
    logic             w_last;
    logic [23:0]      w_sum;
    rcr_pkg::t_status r_status;
    rcr_pkg::t_status n_status;
    logic [23:0]      r_take;

    logic [1:0]  r_o_status;
    logic [23:0] r_o_take;
    logic [23:0] r_o_offset;
    logic [23:0] r_o_len;
    logic [7:0]  r_o_type;
    logic [31:0] r_o_ts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_size <= rcr_pkg::CHUNK_SIZE_RESET;
            r_clr_addr   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_chunk_size <= i_cfg_data;
            end
            if (i_cmd.clear_wr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    assign o_dp_status.clear_last = (r_clr_addr == AW'(CHANNELS - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_channel  <= i_channel;
            r_fmt      <= i_header_format;
            r_len_in   <= i_msg_len_in;
            r_type_in  <= i_msg_type_in;
            r_ts_in    <= i_timestamp_in;
            r_delta_in <= i_delta_in;
            r_avail    <= i_bytes_available;
        end
    end

    assign w_idx = chan_index(r_channel);

    rcr_ram #(
        .WIDTH (EW),
        .DEPTH (CHANNELS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wentry),
        .i_re    (i_cmd.lookup),
        .i_raddr (w_idx),
        .o_rdata (w_rdata)
    );

    assign w_entry = w_rdata;

    // restore omitted fields for a new message, reuse stored ones otherwise
    always_comb begin
        n_len   = w_entry.length;
        n_type  = w_entry.msg_type;
        n_ts    = w_entry.timestamp;
        n_delta = w_entry.delta;
        n_done  = w_entry.received;
        if (!w_entry.in_progress) begin
            n_done = '0;
            if (r_fmt == rcr_pkg::FMT_FULL || r_fmt == rcr_pkg::FMT_SAME_STREAM) begin
                n_len  = r_len_in;
                n_type = r_type_in;
            end
            if (r_fmt != rcr_pkg::FMT_CONT) begin
                n_delta = r_delta_in;
            end
            if (r_fmt == rcr_pkg::FMT_FULL) begin
                n_ts = r_ts_in;
            end else begin
                n_ts = w_entry.timestamp + n_delta;
            end
        end
        w_diff = {1'b0, n_len} - {1'b0, n_done};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.resolve) begin
            r_len   <= n_len;
            r_type  <= n_type;
            r_ts    <= n_ts;
            r_delta <= n_delta;
            r_done  <= n_done;
            r_need  <= w_diff[24] ? 24'd0 : w_diff[23:0];
        end
    end

    // chunk size is the lesser of remaining bytes and the configured size, a size of zero counting as one
    always_comb begin
        w_csz  = (r_chunk_size == 24'd0) ? 24'd1 : r_chunk_size;
        w_size = (r_need > w_csz) ? w_csz : r_need;
        w_ok   = (r_avail >= w_size);
        w_last = (w_size == r_need);
        w_sum  = r_done + w_size;
        if (!w_ok) begin
            n_status = rcr_pkg::ST_WAIT_DATA;
        end else if (w_last) begin
            n_status = rcr_pkg::ST_COMPLETE;
        end else begin
            n_status = rcr_pkg::ST_WAIT_CHUNK;
        end
    end

    always_comb begin
        w_we     = i_cmd.clear_wr || (i_cmd.decide && w_ok);
        w_waddr  = i_cmd.clear_wr ? r_clr_addr : w_idx;
        w_wentry = '0;
        if (!i_cmd.clear_wr) begin
            w_wentry.length      = r_len;
            w_wentry.msg_type    = r_type;
            w_wentry.timestamp   = r_ts;
            w_wentry.delta       = r_delta;
            w_wentry.in_progress = !w_last;
            w_wentry.received    = w_last ? 24'd0 : w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decide) begin
            r_status <= n_status;
            r_take   <= w_ok ? w_size : 24'd0;
        end
        if (i_cmd.load_out) begin
            r_o_status <= r_status;
            r_o_take   <= r_take;
            r_o_offset <= r_done;
            r_o_len    <= r_len;
            r_o_type   <= r_type;
            r_o_ts     <= r_ts;
        end
    end

    assign o_status        = r_o_status;
    assign o_take_bytes    = r_o_take;
    assign o_write_offset  = r_o_offset;
    assign o_msg_total_len = r_o_len;
    assign o_msg_type      = r_o_type;
    assign o_msg_timestamp = r_o_ts;

endmodule

// File: hdl/rcr_checker.sv
// ----------------------------------------------------------------------------
// rcr_checker
// port level checks of the chunk stream reassembler
// ----------------------------------------------------------------------------
module rcr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_status,
    input logic [23:0] o_take_bytes,
    input logic [23:0] o_write_offset,
    input logic [23:0] o_msg_total_len
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_take_bytes)
            && $stable(o_status) && $stable(o_write_offset))
        else $error("result word changed under stall");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == rcr_pkg::ST_WAIT_DATA
            || o_status == rcr_pkg::ST_WAIT_CHUNK || o_status == rcr_pkg::ST_COMPLETE))
        else $error("undefined status code");

    a_wait_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == rcr_pkg::ST_WAIT_DATA |-> o_take_bytes == 24'd0)
        else $error("bytes taken while waiting for data");

    // a chunk never runs past the end of its message
    a_take_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != rcr_pkg::ST_WAIT_DATA
            |-> ({1'b0, o_write_offset} + {1'b0, o_take_bytes}) <= {1'b0, o_msg_total_len})
        else $error("chunk exceeds message length");

endmodule

bind rtmp_chunk_reassembler rcr_checker u_rcr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_status        (o_status),
    .o_take_bytes    (o_take_bytes),
    .o_write_offset  (o_write_offset),
    .o_msg_total_len (o_msg_total_len)
);
